[rtl/base64_stream_decoder_macros.svh]
// Assertion macros used by the base64 stream decoder checker.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef BASE64_STREAM_DECODER_MACROS_SVH
`define BASE64_STREAM_DECODER_MACROS_SVH

// Plain property, checked while out of reset.
`define B64D_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Property that only has to hold in cycles where cond is true.
`define B64D_ASSERT_WHEN(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

`endif

[rtl/b64d_pkg.sv]
// Shared types, character codes and the symbol table of the base64 stream decoder.
// No dependencies; used by every module of the block.
package b64d_pkg;

  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_PAD    = 8'h3D;  // '='
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;

  localparam logic [6:0] SYM_PAD = 7'd64;
  localparam logic [6:0] SYM_BAD = 7'd127;

  localparam logic [23:0] LEN_MAX = 24'hFFFFFF;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_BAD_CHAR      = 3'd1,
    ST_TOO_MANY_PADS = 3'd2,
    ST_DATA_AFTER_PAD = 3'd3,
    ST_EMPTY         = 3'd4
  } status_t;

  // Everything one character produces: up to three bytes and a status record.
  typedef struct packed {
    logic [1:0]  nbytes;
    logic [23:0] word;
    logic        has_status;
    status_t     status;
    logic [23:0] length;
  } bundle_t;

  // 0..63 for data symbols, 64 for pad, 127 for anything else.
  function automatic logic [6:0] sym_value(input logic [7:0] c);
    logic [6:0] v;
    v = SYM_BAD;
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      v = 7'(c - CH_UPPER_A);
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      v = 7'(c - CH_LOWER_A) + 7'd26;
    end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
      v = 7'(c - CH_DIGIT_0) + 7'd52;
    end else if (c == CH_PLUS) begin
      v = 7'd62;
    end else if (c == CH_SLASH) begin
      v = 7'd63;
    end else if (c == CH_PAD) begin
      v = SYM_PAD;
    end
    return v;
  endfunction

endpackage

[rtl/b64d_core.sv]
// Per-character decode: stream state registers, symbol lookup, grouping and status.
// Depends on b64d_pkg; feeds a result bundle to b64d_outq.
module b64d_core
  import b64d_pkg::*;
#(
  parameter int COUNT_WIDTH = 24
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    item_valid,
  input  logic [7:0] item_char,
  input  logic    item_final,
  input  logic    can_load,
  output logic    advance,
  output logic    load,
  output bundle_t bundle
);

  localparam int LW  = COUNT_WIDTH + 4;
  localparam int LFW = COUNT_WIDTH + 1;
  localparam int LCW = (LFW > 24) ? LFW : 24;

  logic                   pcr_r, pcr_nxt;
  status_t                err_r, err_nxt;
  logic [1:0]             pad_r, pad_nxt;
  logic [1:0]             pos_r, pos_nxt;
  logic [17:0]            acc_r, acc_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;

  logic [6:0]     sym;
  logic           is_pad;
  logic [1:0]     pad_inc;
  logic [1:0]     nbytes;
  logic [23:0]    word;
  status_t        status;
  logic [LW-1:0]  prod;
  logic [LCW-1:0] len_ext;
  logic [23:0]    length;
  logic [2:0]     nres;

  always_comb begin
    pcr_nxt = pcr_r;
    err_nxt = err_r;
    pad_nxt = pad_r;
    pos_nxt = pos_r;
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    nbytes  = 2'd0;
    word    = 24'd0;
    sym     = sym_value(item_char);
    is_pad  = (item_char == CH_PAD);
    pad_inc = pad_r + {1'b0, is_pad};

    if (err_r == ST_OK) begin
      if (pcr_r) begin
        pcr_nxt = 1'b0;
        if (item_char != CH_LF) err_nxt = ST_BAD_CHAR;
      end else if (item_char == CH_CR) begin
        if (item_final) err_nxt = ST_BAD_CHAR;
        else pcr_nxt = 1'b1;
      end else if (item_char != CH_LF) begin
        if (is_pad && pad_r >= 2'd2) begin
          err_nxt = ST_TOO_MANY_PADS;
        end else begin
          pad_nxt = pad_inc;
          if (sym == SYM_BAD) begin
            err_nxt = ST_BAD_CHAR;
          end else if (!sym[6] && pad_inc != 2'd0) begin
            err_nxt = ST_DATA_AFTER_PAD;
          end else begin
            if (cnt_r != '1) cnt_nxt = cnt_r + COUNT_WIDTH'(1);
            if (pos_r != 2'd3) begin
              acc_nxt = {acc_r[11:0], sym[5:0]};
              pos_nxt = pos_r + 2'd1;
            end else begin
              word    = {acc_r, sym[5:0]};
              acc_nxt = 18'd0;
              pos_nxt = 2'd0;
              nbytes  = 2'd3 - pad_inc;
            end
          end
        end
      end
    end

    // count*6 + 7, then >> 3
    prod    = ({4'b0, cnt_nxt} << 2) + ({4'b0, cnt_nxt} << 1) + LW'(7);
    len_ext = LCW'(prod[LW-1:3]);

    if (err_nxt == ST_OK && cnt_nxt == '0) status = ST_EMPTY;
    else status = err_nxt;

    if (status != ST_OK) length = 24'd0;
    else if (len_ext > LCW'(LEN_MAX)) length = LEN_MAX;
    else length = len_ext[23:0];

    if (item_final) begin
      pcr_nxt = 1'b0;
      err_nxt = ST_OK;
      pad_nxt = 2'd0;
      pos_nxt = 2'd0;
      acc_nxt = 18'd0;
      cnt_nxt = '0;
    end
  end

  assign nres    = {1'b0, nbytes} + {2'b0, item_final};
  // a character with no results never waits for the output side
  assign advance = item_valid && (can_load || nres == 3'd0);
  assign load    = advance && nres != 3'd0;

  assign bundle.nbytes     = nbytes;
  assign bundle.word       = word;
  assign bundle.has_status = item_final;
  assign bundle.status     = status;
  assign bundle.length     = length;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcr_r <= 1'b0;
      err_r <= ST_OK;
      pad_r <= 2'd0;
      pos_r <= 2'd0;
      acc_r <= 18'd0;
      cnt_r <= '0;
    end else if (advance) begin
      pcr_r <= pcr_nxt;
      err_r <= err_nxt;
      pad_r <= pad_nxt;
      pos_r <= pos_nxt;
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[rtl/b64d_outq.sv]
// Result register: holds one character's bundle and hands out one result word a cycle while out_stall is low.
// Depends on b64d_pkg.
module b64d_outq
  import b64d_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  bundle_t     bundle,
  output logic        can_load,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_item_kind,
  output logic [7:0]  out_data_byte,
  output logic [2:0]  out_status_code,
  output logic [23:0] out_decoded_length,
  output logic        out_run_end
);

  bundle_t    bundle_r;
  logic       bv_r;
  logic [1:0] idx_r;

  logic [2:0] total;
  logic       is_status;
  logic       take;

  assign total     = {1'b0, bundle_r.nbytes} + {2'b0, bundle_r.has_status};
  assign is_status = (idx_r == bundle_r.nbytes);

  assign out_valid          = bv_r;
  assign out_run_end        = ({1'b0, idx_r} == total - 3'd1);
  assign out_item_kind      = is_status;
  assign out_status_code    = is_status ? bundle_r.status : ST_OK;
  assign out_decoded_length = is_status ? bundle_r.length : 24'd0;

  always_comb begin
    case (idx_r)
      2'd0:    out_data_byte = bundle_r.word[23:16];
      2'd1:    out_data_byte = bundle_r.word[15:8];
      2'd2:    out_data_byte = bundle_r.word[7:0];
      default: out_data_byte = 8'd0;
    endcase
    if (is_status) out_data_byte = 8'd0;
  end

  assign take     = bv_r && !out_stall;
  assign can_load = !bv_r || (take && out_run_end);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r  <= 1'b0;
      idx_r <= 2'd0;
    end else if (load) begin
      bundle_r <= bundle;
      bv_r     <= 1'b1;
      idx_r    <= 2'd0;
    end else if (take) begin
      if (out_run_end) bv_r <= 1'b0;
      else idx_r <= idx_r + 2'd1;
    end
  end

endmodule

[rtl/base64_stream_decoder.sv]
// Top level of the base64 stream decoder: input register, decode core, result register.
// Depends on b64d_pkg, b64d_core and b64d_outq.

// Takes one base64 character per accepted word, the last one flagged by in_is_final,
// and returns decoded bytes followed, on the final character, by one status record
// (status and decoded length). Bytes of a text may appear before its error is found;
// drop them when the final status is not ok. Timing: an accepted character is held in
// the input register until the core advances on it; its results are then loaded into
// the result register and handed out from there. Characters that give no result
// pass at one per cycle even while earlier results drain; a character that closes a
// group or ends the text gives up to four results, which leave the result register
// one per cycle while out_stall is low, so the next such character waits until the
// register has drained. Sustained rate on plain text is one character per cycle while
// out_stall stays low.
module base64_stream_decoder
  import b64d_pkg::*;
#(
  parameter int COUNT_WIDTH = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_text_char,
  input  logic        in_is_final,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_item_kind,
  output logic [7:0]  out_data_byte,
  output logic [2:0]  out_status_code,
  output logic [23:0] out_decoded_length,
  output logic        out_run_end
);

  logic       iv_r;
  logic [7:0] char_r;
  logic       final_r;

  logic    advance;
  logic    load;
  logic    can_load;
  bundle_t bundle;

  assign in_stall = iv_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
    end else begin
      iv_r <= (in_valid && !in_stall) || (iv_r && !advance);
      if (in_valid && !in_stall) begin
        char_r  <= in_text_char;
        final_r <= in_is_final;
      end
    end
  end

  b64d_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (iv_r),
    .item_char  (char_r),
    .item_final (final_r),
    .can_load   (can_load),
    .advance    (advance),
    .load       (load),
    .bundle     (bundle)
  );

  b64d_outq u_outq (
    .clk                (clk),
    .rst_n              (rst_n),
    .load               (load),
    .bundle             (bundle),
    .can_load           (can_load),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_item_kind      (out_item_kind),
    .out_data_byte      (out_data_byte),
    .out_status_code    (out_status_code),
    .out_decoded_length (out_decoded_length),
    .out_run_end        (out_run_end)
  );

endmodule

[rtl/b64d_checker.sv]
// Port-level checks on the result channel of the base64 stream decoder.
// Depends on b64d_pkg and base64_stream_decoder_macros.svh; bound to the top level.
`include "base64_stream_decoder_macros.svh"

module b64d_checker
  import b64d_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_item_kind,
  input logic [2:0]  out_status_code,
  input logic [23:0] out_decoded_length,
  input logic        out_run_end
);

  `B64D_ASSERT(a_valid_hold, out_valid && out_stall |=> out_valid, "result word dropped while stalled")
  `B64D_ASSERT(a_run_continues, out_valid && !out_stall && !out_run_end |=> out_valid, "run ended early")
  `B64D_ASSERT_WHEN(a_status_last, out_valid && out_item_kind, out_run_end, "status word not last")
  `B64D_ASSERT_WHEN(a_data_clean, out_valid && !out_item_kind, out_status_code == ST_OK && out_decoded_length == 24'd0, "data word carries status")
  `B64D_ASSERT_WHEN(a_err_len, out_valid && out_item_kind && out_status_code != ST_OK, out_decoded_length == 24'd0, "length on failed text")

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (.*);

[sim/base64_stream_decoder_tb.sv]
// Self-checking testbench for base64_stream_decoder: a directed table, then random texts.
// Depends on b64d_pkg and the RTL; carries its own model of the decoder for prediction.
module base64_stream_decoder_tb;
  import b64d_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_WORDS = 118;
  localparam int TAIL_CYCLES = 20;

  typedef struct packed {
    logic [7:0]  ch;
    logic        fin;
    logic        typed;   // expected status record given by hand
    status_t     t_st;
    logic [23:0] t_len;
  } char_word_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    status_t     status;
    logic [23:0] length;
    logic        last;
  } dec_result_t;

  localparam char_word_t DIR_ROWS [27] = '{
    '{CH_LF,  1'b1, 1'b1, ST_EMPTY,          24'd0},
    '{"T",    1'b0, 1'b0, ST_OK,             24'd0},
    '{"W",    1'b0, 1'b0, ST_OK,             24'd0},
    '{"F",    1'b0, 1'b0, ST_OK,             24'd0},
    '{"u",    1'b0, 1'b0, ST_OK,             24'd0},
    '{CH_CR,  1'b0, 1'b0, ST_OK,             24'd0},
    '{CH_LF,  1'b0, 1'b0, ST_OK,             24'd0},
    '{"Q",    1'b0, 1'b0, ST_OK,             24'd0},
    '{"Q",    1'b0, 1'b0, ST_OK,             24'd0},
    '{CH_PAD, 1'b0, 1'b0, ST_OK,             24'd0},
    '{CH_PAD, 1'b1, 1'b0, ST_OK,             24'd0},
    '{CH_PAD, 1'b0, 1'b0, ST_OK,             24'd0},
    '{CH_PAD, 1'b0, 1'b0, ST_OK,             24'd0},
    '{CH_PAD, 1'b1, 1'b1, ST_TOO_MANY_PADS,  24'd0},
    '{CH_CR,  1'b0, 1'b0, ST_OK,             24'd0},
    '{"A",    1'b1, 1'b1, ST_BAD_CHAR,       24'd0},
    '{"A",    1'b0, 1'b0, ST_OK,             24'd0},
    '{CH_PAD, 1'b0, 1'b0, ST_OK,             24'd0},
    '{"B",    1'b1, 1'b1, ST_DATA_AFTER_PAD, 24'd0},
    '{"+",    1'b0, 1'b0, ST_OK,             24'd0},
    '{"/",    1'b0, 1'b0, ST_OK,             24'd0},
    '{"z",    1'b0, 1'b0, ST_OK,             24'd0},
    '{"9",    1'b0, 1'b0, ST_OK,             24'd0},
    '{CH_CR,  1'b1, 1'b1, ST_BAD_CHAR,       24'd0},
    '{8'h00,  1'b0, 1'b0, ST_OK,             24'd0},
    '{"A",    1'b0, 1'b0, ST_OK,             24'd0},
    '{8'hFF,  1'b1, 1'b1, ST_BAD_CHAR,       24'd0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_text_char = 8'd0;
  logic        in_is_final = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_item_kind;
  logic [7:0]  out_data_byte;
  logic [2:0]  out_status_code;
  logic [23:0] out_decoded_length;
  logic        out_run_end;

  char_word_t  text_q [$];
  dec_result_t expected_q [$];
  char_word_t  cur_word;
  int          tx_idle_pct = 9;
  int          rx_idle_pct = 73;
  int          words_queued = 0;
  int          words_taken = 0;
  int          mismatches = 0;
  int          cycles = 0;

  // decoder state as seen by the prediction
  logic        cr_pending = 1'b0;
  status_t     err_st = ST_OK;
  logic [1:0]  pads = 2'd0;
  logic [1:0]  gpos = 2'd0;
  logic [17:0] acc = 18'd0;
  logic [23:0] nchars = 24'd0;

  base64_stream_decoder u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_text_char       (in_text_char),
    .in_is_final        (in_is_final),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_item_kind      (out_item_kind),
    .out_data_byte      (out_data_byte),
    .out_status_code    (out_status_code),
    .out_decoded_length (out_decoded_length),
    .out_run_end        (out_run_end)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [6:0] sym_of(input logic [7:0] c);
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) return 7'(c - CH_UPPER_A);
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z) return 7'(c - CH_LOWER_A + 8'd26);
    if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) return 7'(c - CH_DIGIT_0 + 8'd52);
    if (c == CH_PLUS) return 7'd62;
    if (c == CH_SLASH) return 7'd63;
    if (c == CH_PAD) return SYM_PAD;
    return SYM_BAD;
  endfunction

  function automatic logic [7:0] char_of(input logic [5:0] v);
    if (v < 6'd26) return CH_UPPER_A + 8'(v);
    if (v < 6'd52) return CH_LOWER_A + 8'(v - 6'd26);
    if (v < 6'd62) return CH_DIGIT_0 + 8'(v - 6'd52);
    if (v == 6'd62) return CH_PLUS;
    return CH_SLASH;
  endfunction

  task automatic decode_char(input char_word_t w);
    dec_result_t r [4];
    int          n;
    int          nb;
    logic [6:0]  v;
    logic [23:0] grp;
    logic [31:0] l;
    status_t     st;
    n = 0;
    if (err_st == ST_OK) begin
      if (cr_pending) begin
        cr_pending = 1'b0;
        if (w.ch != CH_LF) err_st = ST_BAD_CHAR;
      end else if (w.ch == CH_CR) begin
        if (w.fin) err_st = ST_BAD_CHAR;
        else cr_pending = 1'b1;
      end else if (w.ch != CH_LF) begin
        v = sym_of(w.ch);
        // the pad limit is checked ahead of the other symbol checks
        if (w.ch == CH_PAD && pads >= 2'd2) err_st = ST_TOO_MANY_PADS;
        else if (v == SYM_BAD) err_st = ST_BAD_CHAR;
        else if (v < SYM_PAD && pads != 2'd0) err_st = ST_DATA_AFTER_PAD;
        else begin
          if (w.ch == CH_PAD) pads++;
          if (nchars != {24{1'b1}}) nchars++;
          if (gpos != 2'd3) begin
            acc = {acc[11:0], v[5:0]};
            gpos++;
          end else begin
            grp = {acc, v[5:0]};
            acc = 18'd0;
            gpos = 2'd0;
            nb = 3 - int'(pads);
            for (int i = 0; i < nb; i++) begin
              r[n] = '{1'b0, grp[23 - 8 * i -: 8], ST_OK, 24'd0, 1'b0};
              n++;
            end
          end
        end
      end
    end
    if (w.fin) begin
      st = err_st;
      l = 32'd0;
      if (st == ST_OK && nchars == 24'd0) st = ST_EMPTY;
      if (st == ST_OK) begin
        l = ({8'd0, nchars} * 32'd6 + 32'd7) >> 3;
        if (l > {8'd0, LEN_MAX}) l = {8'd0, LEN_MAX};
      end
      r[n] = '{1'b1, 8'd0, st, l[23:0], 1'b0};
      n++;
      cr_pending = 1'b0;
      err_st = ST_OK;
      pads = 2'd0;
      gpos = 2'd0;
      acc = 18'd0;
      nchars = 24'd0;
    end
    if (n > 0) r[n - 1].last = 1'b1;
    if (w.typed) expected_q.push_back('{1'b1, 8'd0, w.t_st, w.t_len, 1'b1});
    else for (int i = 0; i < n; i++) expected_q.push_back(r[i]);
  endtask

  task automatic queue_char(input logic [7:0] c, input logic fin);
    text_q.push_back('{c, fin, 1'b0, ST_OK, 24'd0});
    words_queued++;
  endtask

  // One random text: mostly valid encodings with line breaks, some damaged, some noise.
  task automatic gen_text(inout int count);
    logic [7:0] txt [$];
    logic [7:0] b [3];
    int         kind;
    int         nbytes;
    int         pos;
    int         k;
    kind = $urandom_range(0, 99);
    if (kind < 85) begin
      nbytes = $urandom_range(0, 9);
      for (int g = 0; g < nbytes; g += 3) begin
        for (int j = 0; j < 3; j++) b[j] = (g + j < nbytes) ? 8'($urandom) : 8'd0;
        txt.push_back(char_of(b[0][7:2]));
        txt.push_back(char_of({b[0][1:0], b[1][7:4]}));
        txt.push_back(g + 1 < nbytes ? char_of({b[1][3:0], b[2][7:6]}) : CH_PAD);
        txt.push_back(g + 2 < nbytes ? char_of(b[2][5:0]) : CH_PAD);
        k = $urandom_range(0, 99);
        if (k < 10) begin
          txt.push_back(CH_CR);
          txt.push_back(CH_LF);
        end else if (k < 15) begin
          txt.push_back(CH_LF);
        end
      end
      // trailing partial group
      if (txt.size() > 3 && $urandom_range(0, 99) < 12) begin
        k = $urandom_range(1, 3);
        repeat (k) void'(txt.pop_back());
      end
      if (kind >= 70 && txt.size() > 0) begin
        pos = $urandom_range(0, txt.size() - 1);
        case ($urandom_range(0, 3))
          0: txt[pos] = 8'($urandom);
          1: txt.insert(pos, CH_CR);
          2: txt.insert(pos, CH_PAD);
          default: txt.insert(pos, 8'($urandom_range(128, 255)));
        endcase
      end
      if (txt.size() == 0 || $urandom_range(0, 99) < 10) txt.push_back(CH_LF);
    end else begin
      k = $urandom_range(1, 8);
      repeat (k) begin
        if ($urandom_range(0, 1) == 0) txt.push_back(8'($urandom));
        else txt.push_back(char_of(6'($urandom)));
      end
    end
    foreach (txt[i]) queue_char(txt[i], i == txt.size() - 1);
    count += txt.size();
  endtask

  task automatic report(input string what, input dec_result_t e, input dec_result_t a);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch (%s): expected kind %0d data %02h st %0d len %0d end %0d,",
               what, e.kind, e.data, e.status, e.length, e.last,
               " got kind %0d data %02h st %0d len %0d end %0d",
               a.kind, a.data, a.status, a.length, a.last);
  endtask

  // sender side
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_char(cur_word);
        words_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (text_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          cur_word = text_q.pop_front();
          in_valid <= 1'b1;
          in_text_char <= cur_word.ch;
          in_is_final <= cur_word.fin;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver side
  always @(posedge clk) begin
    dec_result_t got;
    dec_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{out_item_kind, out_data_byte, status_t'(out_status_code),
                out_decoded_length, out_run_end};
        if (expected_q.size() == 0) begin
          report("unexpected word", '0, got);
        end else begin
          want = expected_q.pop_front();
          if (got.kind != want.kind || got.data != want.data ||
              got.status != want.status || got.length != want.length ||
              got.last != want.last)
            report("field", want, got);
        end
      end
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int tx_pct [3];
    int rx_pct [3];
    int count;
    tx_pct = '{9, 73, 0};
    rx_pct = '{73, 9, 0};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (DIR_ROWS[i]) begin
      text_q.push_back(DIR_ROWS[i]);
      words_queued++;
    end
    for (int p = 0; p < 3; p++) begin
      tx_idle_pct = tx_pct[p];
      rx_idle_pct = rx_pct[p];
      count = 0;
      while (count < PHASE_WORDS) gen_text(count);
      while (text_q.size() != 0) @(posedge clk);
    end
    while (words_taken != words_queued || expected_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
